@@ rtl/u16u8_pkg.sv @@
`default_nettype none

package u16u8_pkg;

	// Widths
	localparam int UNIT_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int CP_W     = 21;
	localparam int SUR_W    = 10;
	localparam int RUN_MAX  = 6;
	localparam int CNT_W    = 3;
	localparam int IDX_W    = 3;

	// Code point range bounds
	localparam logic [CP_W-1:0]   CP_1B_MAX   = 21'h00007f;
	localparam logic [CP_W-1:0]   CP_2B_MAX   = 21'h0007ff;
	localparam logic [CP_W-1:0]   CP_3B_MAX   = 21'h00ffff;
	localparam logic [CP_W-1:0]   CP_SUPP_BASE = 21'h010000;

	// Surrogate ranges
	localparam logic [UNIT_W-1:0] HIGH_SUR_MIN = 16'hd800;
	localparam logic [UNIT_W-1:0] HIGH_SUR_MAX = 16'hdbff;
	localparam logic [UNIT_W-1:0] LOW_SUR_MIN  = 16'hdc00;
	localparam logic [UNIT_W-1:0] LOW_SUR_MAX  = 16'hdfff;
	localparam logic [5:0]        HIGH_SUR_TAG = 6'b110110;

	// UTF-8 lead and continuation tags
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;
	localparam logic [1:0] CONT_TAG  = 2'b10;

	typedef logic [BYTE_W-1:0] byte_t;

	// Encoding of one code point: up to four bytes, lowest index goes first
	typedef struct packed {
		byte_t [3:0]      data;
		logic [CNT_W-1:0] n;
	} pt_enc_t;

	// One run of bytes caused by one item
	typedef struct packed {
		byte_t [RUN_MAX-1:0] data;
		logic [CNT_W-1:0]    cnt;
	} out_run_t;

	// Encoder result: run plus next held-surrogate state
	typedef struct packed {
		out_run_t         run;
		logic             hold;
		logic [SUR_W-1:0] hold_sur;
	} enc_res_t;

	function automatic pt_enc_t encode_point(input logic [CP_W-1:0] cp);
		pt_enc_t r;
		r.data = '0;
		if (cp <= CP_1B_MAX) begin
			r.data[0] = cp[7:0];
			r.n       = 3'd1;
		end else if (cp <= CP_2B_MAX) begin
			r.data[0] = {LEAD2_TAG, cp[10:6]};
			r.data[1] = {CONT_TAG, cp[5:0]};
			r.n       = 3'd2;
		end else if (cp <= CP_3B_MAX) begin
			r.data[0] = {LEAD3_TAG, cp[15:12]};
			r.data[1] = {CONT_TAG, cp[11:6]};
			r.data[2] = {CONT_TAG, cp[5:0]};
			r.n       = 3'd3;
		end else begin
			r.data[0] = {LEAD4_TAG, cp[20:18]};
			r.data[1] = {CONT_TAG, cp[17:12]};
			r.data[2] = {CONT_TAG, cp[11:6]};
			r.data[3] = {CONT_TAG, cp[5:0]};
			r.n       = 3'd4;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/utf16_to_utf8_transcoder_core.sv @@
// An accepted unit is registered in the input stage, encoded combinationally and
//   loaded into the run buffer, which presents its first byte; the load waits while a run drains.
// Throughput: one byte per cycle on the output while m_axis_tready is high; an item
//   causes 1 to 6 bytes, a held high surrogate none.
// Input register and output run buffer overlap, so the next item is taken
//   while the current run drains.
// Reset: arst_n clears the input stage, the held surrogate and the run buffer.
`default_nettype none

module utf16_to_utf8_transcoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // code_unit[15:0]
	input  wire logic        s_axis_tlast,  // last_unit
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // utf8_byte[7:0]
	output logic             m_axis_tlast   // run_end
);
	import u16u8_pkg::*;

	logic [UNIT_W-1:0] unit_s1;
	logic              last_s1;
	logic              vld_s1;
	logic              held_valid_q;
	logic [SUR_W-1:0]  held_q;
	enc_res_t          enc_res;
	logic              buf_ready;
	logic              run_valid;
	logic              consume;
	logic              in_take;

	// Input stage
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign run_valid     = vld_s1 && (enc_res.run.cnt != '0);
	assign consume       = vld_s1 && ((enc_res.run.cnt == '0) || buf_ready);
	assign s_axis_tready = !vld_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			unit_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Held high surrogate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_q       <= '0;
		end else if (consume) begin
			held_valid_q <= enc_res.hold;
			held_q       <= enc_res.hold_sur;
		end
	end

	u16u8_encoder u_encoder (
		.unit       (unit_s1),
		.last       (last_s1),
		.held_valid (held_valid_q),
		.held_sur   (held_q),
		.res        (enc_res)
	);

	u16u8_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_valid    (run_valid),
		.load_run      (enc_res.run),
		.load_ready    (buf_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Checks
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (enc_res.run.cnt <= 3'd6))
		else $error("run length above six bytes");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> vld_s1)
		else $error("input stalled with empty stage");

	a_silent_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && (enc_res.run.cnt == '0)) |=> held_valid_q)
		else $error("item with no bytes did not hold a surrogate");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && last_s1) |=> !held_valid_q)
		else $error("surrogate held across end of text");

endmodule

`default_nettype wire

@@ rtl/u16u8_encoder.sv @@
`default_nettype none

module u16u8_encoder (
	input  wire logic [u16u8_pkg::UNIT_W-1:0] unit,
	input  wire logic                         last,
	input  wire logic                         held_valid,
	input  wire logic [u16u8_pkg::SUR_W-1:0]  held_sur,
	output u16u8_pkg::enc_res_t               res
);
	import u16u8_pkg::*;

	logic             is_low;
	logic             is_high;
	logic             hold_new;
	logic [CP_W-1:0]  pair_cp;
	pt_enc_t          pair_enc;
	pt_enc_t          pre_enc;
	pt_enc_t          cur_enc;

	// Classify the unit
	assign is_low   = (unit >= LOW_SUR_MIN) && (unit <= LOW_SUR_MAX);
	assign is_high  = (unit >= HIGH_SUR_MIN) && (unit <= HIGH_SUR_MAX);
	assign hold_new = is_high && !last && !(held_valid && is_low);

	// Supplementary code point from a surrogate pair
	assign pair_cp  = CP_SUPP_BASE + {1'b0, held_sur, unit[SUR_W-1:0]};
	assign pair_enc = encode_point(pair_cp);
	assign pre_enc  = encode_point({5'd0, HIGH_SUR_TAG, held_sur});
	assign cur_enc  = encode_point({5'd0, unit});

	// Assemble the run: a surrogate pair gives one code point; else held prefix first, then the current unit
	always_comb begin
		res          = '0;
		res.hold     = hold_new;
		res.hold_sur = hold_new ? unit[SUR_W-1:0] : '0;
		if (held_valid && is_low) begin
			res.run.data[3:0] = pair_enc.data;
			res.run.cnt       = pair_enc.n;
		end else if (held_valid) begin
			res.run.data[2:0] = pre_enc.data[2:0];
			if (hold_new) begin
				res.run.cnt = 3'd3;
			end else begin
				res.run.data[5:3] = cur_enc.data[2:0];
				res.run.cnt       = 3'd3 + cur_enc.n;
			end
		end else if (!hold_new) begin
			res.run.data[3:0] = cur_enc.data;
			res.run.cnt       = cur_enc.n;
		end
	end

endmodule

`default_nettype wire

@@ rtl/u16u8_out_buf.sv @@
`default_nettype none

module u16u8_out_buf (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load_valid,
	input  wire u16u8_pkg::out_run_t         load_run,
	output logic                             load_ready,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [7:0]                       m_axis_tdata,  // utf8_byte[7:0]
	output logic                             m_axis_tlast   // run_end
);
	import u16u8_pkg::*;

	byte_t [RUN_MAX-1:0] buf_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    idx_q;
	logic                at_last;
	logic                take;
	logic                load;

	assign at_last       = (idx_q == (cnt_q - 3'd1));
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = buf_q[idx_q];
	assign m_axis_tlast  = at_last;
	assign take          = m_axis_tvalid && m_axis_tready;
	// Free when empty or the final byte of the run leaves this cycle
	assign load_ready    = !m_axis_tvalid || (take && at_last);
	assign load          = load_valid && load_ready;

	// Run counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= load_run.cnt;
			idx_q <= '0;
		end else if (take) begin
			if (at_last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Byte storage
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= load_run.data;
		end
	end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int          CLK_HALF      = 5;
	localparam int          IDLE_LIMIT    = 2000;
	localparam int          DRAIN_CYCLES  = 20;
	localparam int          TEXT_ITEMS    = 200;
	localparam int          NOISE_ITEMS   = 100;

	localparam logic [15:0] HIGH_SUR_LO   = 16'hd800;
	localparam logic [15:0] HIGH_SUR_HI   = 16'hdbff;
	localparam logic [15:0] LOW_SUR_LO    = 16'hdc00;
	localparam logic [15:0] LOW_SUR_HI    = 16'hdfff;
	localparam logic [5:0]  HIGH_SUR_BITS = 6'b110110;
	localparam logic [20:0] ONE_BYTE_MAX  = 21'h00007f;
	localparam logic [20:0] TWO_BYTE_MAX  = 21'h0007ff;
	localparam logic [20:0] BMP_MAX       = 21'h00ffff;
	localparam logic [20:0] SUPP_BASE     = 21'h010000;

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
	} utf8_out_t;

	typedef enum {RX_ALWAYS, RX_COIN, RX_STALLS} rx_mode_t;

	// DUT ports
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;

	// predictor state and expected output bytes
	logic [9:0]  held_high    = '0;
	logic        held_pending = 1'b0;
	logic [7:0]  run_buf[$];
	utf8_out_t   expected_utf8[$];
	utf8_out_t   head_byte;

	int          fail_count   = 0;
	int          idle_cycles  = 0;
	int          burst_left   = 0;
	int          rx_stall_left = 0;
	int          rx_mode_left = 0;
	rx_mode_t    rx_mode      = RX_ALWAYS;

	utf16_to_utf8_transcoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // code_unit[15:0]
		.s_axis_tlast  (s_axis_tlast),   // last_unit
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // utf8_byte[7:0]
		.m_axis_tlast  (m_axis_tlast)    // run_end
	);

	always #CLK_HALF clk = ~clk;

	// UTF-8 bytes of one code point, appended to the current run
	function automatic void emit_code_point(input logic [20:0] cp);
		if (cp <= ONE_BYTE_MAX) begin
			run_buf.push_back(cp[7:0]);
		end else if (cp <= TWO_BYTE_MAX) begin
			run_buf.push_back({3'b110, cp[10:6]});
			run_buf.push_back({2'b10, cp[5:0]});
		end else if (cp <= BMP_MAX) begin
			run_buf.push_back({4'b1110, cp[15:12]});
			run_buf.push_back({2'b10, cp[11:6]});
			run_buf.push_back({2'b10, cp[5:0]});
		end else begin
			run_buf.push_back({5'b11110, cp[20:18]});
			run_buf.push_back({2'b10, cp[17:12]});
			run_buf.push_back({2'b10, cp[11:6]});
			run_buf.push_back({2'b10, cp[5:0]});
		end
	endfunction

	// Expected bytes for one accepted code unit; updates the held surrogate
	function automatic void predict_utf8_bytes(input logic [15:0] unit, input logic is_last);
		logic is_high;
		logic is_low;
		run_buf.delete();
		is_high = unit >= HIGH_SUR_LO && unit <= HIGH_SUR_HI;
		is_low  = unit >= LOW_SUR_LO && unit <= LOW_SUR_HI;
		if (held_pending && is_low) begin
			// surrogate pair -> supplementary code point
			emit_code_point(SUPP_BASE + {1'b0, held_high, unit[9:0]});
			held_pending = 1'b0;
			held_high    = '0;
		end else begin
			// held surrogate had no partner: it goes out alone
			if (held_pending) begin
				emit_code_point({5'b0, HIGH_SUR_BITS, held_high});
				held_pending = 1'b0;
				held_high    = '0;
			end
			if (is_high && !is_last) begin
				held_high    = unit[9:0];
				held_pending = 1'b1;
			end else begin
				emit_code_point({5'b0, unit});
			end
		end
		foreach (run_buf[i])
			expected_utf8.push_back('{data: run_buf[i], run_end: (i == run_buf.size() - 1)});
	endfunction

	// Send one code unit; bursts of items separated by random gaps
	task automatic send_unit(input logic [15:0] unit, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= unit;
		s_axis_tlast  <= is_last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_utf8_bytes(unit, is_last);
	endtask

	// Hold the sender until every expected byte is out, then let the pipe settle
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		while (expected_utf8.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Range boundaries and surrogate corner cases
	task automatic test_encoding_edges();
		send_unit(16'h0000, 1'b0);
		send_unit(16'h007f, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07ff, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hd7ff, 1'b0);
		send_unit(16'he000, 1'b0);
		send_unit(16'hffff, 1'b1);
		// lowest and highest pairs
		send_unit(16'hd800, 1'b0);
		send_unit(16'hdc00, 1'b0);
		send_unit(16'hdbff, 1'b0);
		send_unit(16'hdfff, 1'b1);
		// lone low surrogates
		send_unit(16'hdc00, 1'b0);
		send_unit(16'hdfff, 1'b0);
		// held high followed by a plain unit
		send_unit(16'hd801, 1'b0);
		send_unit(16'h0041, 1'b0);
		// held high followed by another high, which then pairs
		send_unit(16'hda00, 1'b0);
		send_unit(16'hdb00, 1'b0);
		send_unit(16'hdc10, 1'b0);
		// high surrogate as the final unit is never held
		send_unit(16'hd800, 1'b1);
		// held high, then a high that is the final unit
		send_unit(16'hd900, 1'b0);
		send_unit(16'hdbff, 1'b1);
		// final unit clears state: next low is lone
		send_unit(16'hdc55, 1'b0);
		send_unit(16'h0000, 1'b1);
		wait_for_drain();
	endtask

	// Well-formed texts of random characters from every encoding length
	task automatic test_wellformed_text();
		int sent;
		int chars;
		logic [15:0] unit;
		sent = 0;
		while (sent < TEXT_ITEMS) begin
			chars = $urandom_range(1, 8);
			for (int c = 0; c < chars; c++) begin
				case ($urandom_range(0, 3))
					0: send_unit(16'($urandom_range(16'h0000, 16'h007f)), c == chars - 1);
					1: send_unit(16'($urandom_range(16'h0080, 16'h07ff)), c == chars - 1);
					2: begin
						if ($urandom_range(0, 1) == 0)
							unit = 16'($urandom_range(16'h0800, 16'hd7ff));
						else
							unit = 16'($urandom_range(16'he000, 16'hffff));
						send_unit(unit, c == chars - 1);
					end
					default: begin
						send_unit(16'($urandom_range(HIGH_SUR_LO, HIGH_SUR_HI)), 1'b0);
						send_unit(16'($urandom_range(LOW_SUR_LO, LOW_SUR_HI)),
							c == chars - 1);
						sent++;
					end
				endcase
				sent++;
			end
		end
		wait_for_drain();
	endtask

	// Arbitrary units, heavy on unpaired and misordered surrogates
	task automatic test_noisy_units();
		logic [15:0] unit;
		logic        is_last;
		for (int i = 0; i < NOISE_ITEMS; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: unit = 16'($urandom_range(0, 16'hffff));
				4, 5:       unit = 16'($urandom_range(HIGH_SUR_LO, HIGH_SUR_HI));
				6, 7:       unit = 16'($urandom_range(LOW_SUR_LO, LOW_SUR_HI));
				default:    unit = 16'($urandom_range(16'h0000, 16'h007f));
			endcase
			is_last = ($urandom_range(0, 7) == 0);
			send_unit(unit, is_last);
		end
		wait_for_drain();
	endtask

	// Receiver back-pressure: the mode switches at random times
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      = rx_mode_t'($urandom_range(0, 2));
			rx_mode_left = $urandom_range(16, 96);
		end else begin
			rx_mode_left--;
		end
		if (rx_stall_left != 0) begin
			rx_stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 5) == 0) begin
						rx_stall_left = $urandom_range(1, 8);
						m_axis_tready <= 1'b0;
					end else begin
						m_axis_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Compare each output byte with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_utf8.size() == 0) begin
				$display("%0t: unexpected byte, expected none, got %h last %b",
					$time, m_axis_tdata, m_axis_tlast);
				fail_count++;
			end else begin
				head_byte = expected_utf8.pop_front();
				if (m_axis_tdata !== head_byte.data) begin
					$display("%0t: utf8_byte mismatch, expected %h, got %h",
						$time, head_byte.data, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tlast !== head_byte.run_end) begin
					$display("%0t: run_end mismatch, expected %b, got %b",
						$time, head_byte.run_end, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encoding_edges();
		test_wellformed_text();
		test_noisy_units();
		if (fail_count == 0 && expected_utf8.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/u16u8_pkg.sv
rtl/u16u8_encoder.sv
rtl/u16u8_out_buf.sv
rtl/utf16_to_utf8_transcoder_core.sv
tb/testbench.sv
